FILE: hdl/tks_pkg.sv
`default_nettype none
package tks_pkg;

	localparam int NAME_WORDS = 4;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_OFFER = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	typedef logic [NAME_WORDS-1:0][63:0] name_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [63:0]       name_word0;
		logic [63:0]       name_word1;
		logic [63:0]       name_word2;
		logic [63:0]       name_word3;
		logic signed [7:0] strength;
		logic [3:0]        read_index;
		logic              batch_end;
	} in_t;

	typedef struct packed {
		logic [4:0]        entry_count;
		logic [63:0]       out_word0;
		logic [63:0]       out_word1;
		logic [63:0]       out_word2;
		logic [63:0]       out_word3;
		logic signed [7:0] out_strength;
		logic              out_valid;
		logic              batch_done;
	} out_t;

	typedef struct packed {
		name_t             name;
		logic signed [7:0] strength;
	} entry_t;

	// Every byte after the first zero byte reads as zero.
	function automatic name_t clean_name(input name_t raw);
		name_t res;
		logic ended;
		res = '0;
		ended = 1'b0;
		for (int w = 0; w < NAME_WORDS; w++) begin
			for (int b = 0; b < 8; b++) begin
				if (raw[w][8*b +: 8] == 8'd0) begin
					ended = 1'b1;
				end
				if (!ended) begin
					res[w][8*b +: 8] = raw[w][8*b +: 8];
				end
			end
		end
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/top_k_signal_table_with_dedup_unit.sv
// A clear goes from idle through S_FIN to the done strobe; a read of a valid index first fetches its entry in S_READ.
// In an offer, the search, the removal of an older copy, the search for the insert place and
// the shift each visit entries one at a time through the entry memory, which has one read and
// one write port; each entry waits on ph_q for the memory's read data, which is registered.
// One command at a time; busy stays high until the done strobe. The receiver cannot stall.
// Reset clears the entry count and the excluded name; the entry memory is not cleared.
`default_nettype none
module top_k_signal_table_with_dedup_unit
	import tks_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_t         cmd,
	output logic             done,
	output out_t             result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int ECW = (CW > 5) ? CW : 5;
	localparam int IW = (AW > 4) ? AW : 4;
	localparam int RCW = (CW > 4) ? CW : 4;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_SRCH  = 4'd2;
	localparam logic [3:0] S_REM   = 4'd3;
	localparam logic [3:0] S_FULL  = 4'd4;
	localparam logic [3:0] S_FIND  = 4'd5;
	localparam logic [3:0] S_SHUP  = 4'd6;
	localparam logic [3:0] S_READ  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0]        state_q;
	logic              ph_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     at_q;
	logic [1:0]        act_q;
	name_t             name_q;
	logic signed [7:0] str_q;
	logic [3:0]        ridx_q;
	logic              bend_q;
	entry_t            rdat_q;
	logic              rvalid_q;
	logic [63:0]       ex_q [NAME_WORDS];

	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [AW-1:0] raddr;
	entry_t        rdata;

	name_t         excl;
	name_t         raw_in;
	logic [IW-1:0] ridx_w;
	logic [ECW-1:0] cnt_w;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] idx_dec;

	tks_entry_ram #(
		.DEPTH(MAX_ENTRIES),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign pready = 1'b1;
	assign prdata = ex_q[paddr[4:3]];
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAME_WORDS; i++) begin
				ex_q[i] <= '0;
			end
		end else if (psel && penable && pwrite) begin
			ex_q[paddr[4:3]] <= pwdata;
		end
	end

	always_comb begin
		for (int i = 0; i < NAME_WORDS; i++) begin
			raw_in[i] = ex_q[i];
		end
		excl = clean_name(raw_in);
	end

	assign ridx_w = IW'(ridx_q);
	assign cnt_w = ECW'(cnt_q);
	assign idx_inc = idx_q + CW'(1);
	assign idx_dec = idx_q - CW'(1);

	// Memory port control for the current step.
	always_comb begin
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		case (state_q)
			S_READ: begin
				raddr = ridx_w[AW-1:0];
			end
			S_REM: begin
				raddr = idx_inc[AW-1:0];
				we = ph_q;
			end
			S_FULL: begin
				raddr = AW'(MAX_ENTRIES - 1);
			end
			S_SHUP: begin
				raddr = idx_dec[AW-1:0];
				if (idx_q == at_q) begin
					we = ~ph_q;
					wdata.name = name_q;
					wdata.strength = str_q;
				end else begin
					we = ph_q;
				end
			end
			default: begin
				raddr = idx_q[AW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
			at_q <= '0;
			done <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					ph_q <= 1'b0;
					if (start) begin
						rvalid_q <= 1'b0;
						case (cmd.action)
							ACT_CLEAR: begin
								cnt_q <= '0;
								state_q <= S_FIN;
							end
							ACT_OFFER: begin
								state_q <= S_CHECK;
							end
							ACT_READ: begin
								if (RCW'(cmd.read_index) < RCW'(cnt_q)) begin
									state_q <= S_READ;
								end else begin
									state_q <= S_FIN;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_READ: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						rvalid_q <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_CHECK: begin
					idx_q <= '0;
					ph_q <= 1'b0;
					if (name_q[0][7:0] == 8'd0) begin
						state_q <= S_FIN;
					end else if (excl[0][7:0] != 8'd0 && excl == name_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (!ph_q) begin
						if (idx_q == cnt_q) begin
							state_q <= S_FULL;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						if (rdata.name == name_q) begin
							if (str_q <= rdata.strength) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_REM;
							end
						end else begin
							idx_q <= idx_inc;
						end
					end
				end
				S_REM: begin
					// Close the gap left by the old copy of the name.
					if (!ph_q) begin
						if (idx_inc >= cnt_q) begin
							cnt_q <= cnt_q - CW'(1);
							idx_q <= '0;
							state_q <= S_FIND;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						idx_q <= idx_inc;
					end
				end
				S_FULL: begin
					if (cnt_q < CW'(MAX_ENTRIES)) begin
						idx_q <= '0;
						state_q <= S_FIND;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (str_q <= rdata.strength) begin
							state_q <= S_FIN;
						end else begin
							cnt_q <= CW'(MAX_ENTRIES - 1);
							idx_q <= '0;
							state_q <= S_FIND;
						end
					end
				end
				S_FIND: begin
					if (!ph_q) begin
						if (idx_q == cnt_q) begin
							at_q <= cnt_q;
							state_q <= S_SHUP;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						if (str_q > rdata.strength) begin
							at_q <= idx_q;
							idx_q <= cnt_q;
							state_q <= S_SHUP;
						end else begin
							idx_q <= idx_inc;
						end
					end
				end
				S_SHUP: begin
					// Move entries up one place from the end down to the insert place,
					// then write the new word there.
					if (!ph_q) begin
						if (idx_q == at_q) begin
							cnt_q <= cnt_q + CW'(1);
							state_q <= S_FIN;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						idx_q <= idx_dec;
					end
				end
				S_FIN: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			act_q <= cmd.action;
			name_q <= clean_name({cmd.name_word3, cmd.name_word2, cmd.name_word1,
				cmd.name_word0});
			str_q <= cmd.strength;
			ridx_q <= cmd.read_index;
			bend_q <= cmd.batch_end;
		end
		if (state_q == S_READ && ph_q) begin
			rdat_q <= rdata;
		end
		if (state_q == S_FIN) begin
			result.entry_count <= cnt_w[4:0];
			result.out_word0 <= rvalid_q ? rdat_q.name[0] : 64'd0;
			result.out_word1 <= rvalid_q ? rdat_q.name[1] : 64'd0;
			result.out_word2 <= rvalid_q ? rdat_q.name[2] : 64'd0;
			result.out_word3 <= rvalid_q ? rdat_q.name[3] : 64'd0;
			result.out_strength <= rvalid_q ? rdat_q.strength : 8'sd0;
			result.out_valid <= rvalid_q;
			result.batch_done <= (act_q == ACT_OFFER) ? bend_q : 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/tks_entry_ram.sv
`default_nettype none
module tks_entry_ram
	import tks_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: tb/signal_table_checker.sv
module signal_table_checker
	import tks_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire in_t         cmd,
	input  wire logic        done,
	input  wire out_t        result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output int unsigned      fail_count,
	output int unsigned      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	name_t             table_name [MAX_ENTRIES];
	logic signed [7:0] table_strength [MAX_ENTRIES];
	int                table_fill;
	name_t             exclude_raw;
	out_t              due_results [$];

	// Names compare as C strings, so everything past the first NUL byte is dropped.
	function automatic name_t strip_tail(input name_t raw);
		logic [255:0] flat;
		bit seen_nul;
		flat = raw;
		seen_nul = 1'b0;
		for (int k = 0; k < 32; k++) begin
			if (flat[8*k +: 8] == 8'h00) begin
				seen_nul = 1'b1;
			end
			if (seen_nul) begin
				flat[8*k +: 8] = 8'h00;
			end
		end
		return flat;
	endfunction

	task automatic place_entry(input name_t nm, input logic signed [7:0] s);
		int at;
		if (table_fill >= MAX_ENTRIES) begin
			if (s <= table_strength[MAX_ENTRIES-1]) begin
				return;
			end
			table_fill = MAX_ENTRIES - 1;
		end
		at = table_fill;
		for (int i = 0; i < table_fill; i++) begin
			if (s > table_strength[i]) begin
				at = i;
				break;
			end
		end
		for (int i = table_fill; i > at; i--) begin
			table_name[i] = table_name[i-1];
			table_strength[i] = table_strength[i-1];
		end
		table_name[at] = nm;
		table_strength[at] = s;
		table_fill++;
	endtask

	task automatic offer_entry(input name_t raw, input logic signed [7:0] s);
		name_t nm;
		name_t ex;
		nm = strip_tail(raw);
		ex = strip_tail(exclude_raw);
		if (nm[0][7:0] == 8'h00) begin
			return;
		end
		if (ex[0][7:0] != 8'h00 && nm == ex) begin
			return;
		end
		for (int i = 0; i < table_fill; i++) begin
			if (table_name[i] == nm) begin
				if (s <= table_strength[i]) begin
					return;
				end
				// A stronger sighting takes the old copy out before it is placed again.
				for (int j = i; j + 1 < table_fill; j++) begin
					table_name[j] = table_name[j+1];
					table_strength[j] = table_strength[j+1];
				end
				table_fill--;
				break;
			end
		end
		place_entry(nm, s);
	endtask

	task automatic advance_table(input in_t c, output out_t r);
		r = '0;
		case (c.action)
			ACT_CLEAR: begin
				table_fill = 0;
			end
			ACT_OFFER: begin
				offer_entry({c.name_word3, c.name_word2, c.name_word1, c.name_word0},
					c.strength);
				r.batch_done = c.batch_end;
			end
			ACT_READ: begin
				if (c.read_index < table_fill) begin
					r.out_word0 = table_name[c.read_index][0];
					r.out_word1 = table_name[c.read_index][1];
					r.out_word2 = table_name[c.read_index][2];
					r.out_word3 = table_name[c.read_index][3];
					r.out_strength = table_strength[c.read_index];
					r.out_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.entry_count = 5'(table_fill);
	endtask

	task automatic check_field(input string field, input logic [63:0] want_v,
		input logic [63:0] got_v);
		if (got_v !== want_v) begin
			fail_count++;
			$display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			table_fill = 0;
			exclude_raw = '0;
			due_results.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				exclude_raw[paddr[4:3]] = pwdata;
			end
			// Retire first: a word finishing on this edge belongs to an older command.
			if (done) begin
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: result word with nothing expected, got %h", $time,
						result);
				end else begin
					want = due_results.pop_front();
					check_field("entry_count", 64'(want.entry_count),
						64'(result.entry_count));
					check_field("out_word0", want.out_word0, result.out_word0);
					check_field("out_word1", want.out_word1, result.out_word1);
					check_field("out_word2", want.out_word2, result.out_word2);
					check_field("out_word3", want.out_word3, result.out_word3);
					check_field("out_strength", 64'(want.out_strength),
						64'(result.out_strength));
					check_field("out_valid", 64'(want.out_valid), 64'(result.out_valid));
					check_field("batch_done", 64'(want.batch_done),
						64'(result.batch_done));
				end
			end
			if (start && !busy) begin
				advance_table(cmd, want);
				due_results.push_back(want);
			end
			pending = due_results.size();
		end
	end

endmodule

FILE: tb/tb_top_k_signal_table_with_dedup_unit.sv
module tb_top_k_signal_table_with_dedup_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import tks_pkg::*;

	localparam int MAX_ENTRIES = 16;
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam logic [4:0] REG_EXCLUDE_W0 = 5'd0;
	localparam logic [4:0] REG_EXCLUDE_W1 = 5'd8;
	localparam logic [4:0] REG_EXCLUDE_W2 = 5'd16;
	localparam logic [4:0] REG_EXCLUDE_W3 = 5'd24;
	localparam logic [4:0] EXCLUDE_ADDR [NAME_WORDS] =
		'{REG_EXCLUDE_W0, REG_EXCLUDE_W1, REG_EXCLUDE_W2, REG_EXCLUDE_W3};
	localparam int POOL_SIZE = 20;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 135;
	localparam int QUIET_FROM = 300;
	localparam int QUIET_TO = 450;
	localparam int TAIL_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         cmd;
	logic        done;
	out_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	int unsigned fail_count;
	int unsigned pending;
	int          idle_cycles;
	int          items_sent;
	name_t       pool [POOL_SIZE];
	name_t       excl_now;

	top_k_signal_table_with_dedup_unit #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	signal_table_checker #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("tb_top_k_signal_table_with_dedup_unit failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic in_t random_cmd();
		in_t c;
		c.action = 2'($urandom_range(0, 3));
		c.name_word0 = rand64();
		c.name_word1 = rand64();
		c.name_word2 = rand64();
		c.name_word3 = rand64();
		c.strength = 8'($urandom);
		c.read_index = 4'($urandom);
		c.batch_end = 1'($urandom);
		return c;
	endfunction

	function automatic in_t offer_cmd(input name_t n, input logic signed [7:0] s,
		input bit last);
		in_t c;
		c = random_cmd();
		c.action = ACT_OFFER;
		c.name_word0 = n[0];
		c.name_word1 = n[1];
		c.name_word2 = n[2];
		c.name_word3 = n[3];
		c.strength = s;
		c.batch_end = last;
		return c;
	endfunction

	function automatic in_t read_cmd(input logic [3:0] idx);
		in_t c;
		c = random_cmd();
		c.action = ACT_READ;
		c.read_index = idx;
		return c;
	endfunction

	// Fills random bytes after the terminator, which must not change the name.
	function automatic name_t with_junk_tail(input name_t n);
		logic [255:0] flat;
		bit past_end;
		flat = n;
		past_end = 1'b0;
		for (int k = 0; k < 32; k++) begin
			if (past_end && $urandom_range(0, 1)) begin
				flat[8*k +: 8] = 8'($urandom);
			end
			if (flat[8*k +: 8] == 8'h00) begin
				past_end = 1'b1;
			end
		end
		return flat;
	endfunction

	function automatic logic signed [7:0] pick_strength();
		int r;
		r = $urandom_range(0, 99);
		// Half the time a narrow band from -80 to -60 dBm so that ties are common.
		if (r < 50) begin
			return 8'($urandom_range(176, 196));
		end
		if (r < 85) begin
			return 8'($urandom);
		end
		return (r < 93) ? 8'sh7F : 8'sh80;
	endfunction

	function automatic name_t pick_name();
		int r;
		logic [255:0] flat;
		r = $urandom_range(0, 99);
		if (r < 74) begin
			return with_junk_tail(pool[$urandom_range(0, POOL_SIZE - 1)]);
		end
		if (r < 84) begin
			return with_junk_tail(excl_now);
		end
		flat = {rand64(), rand64(), rand64(), rand64()};
		if (r < 93) begin
			return flat;
		end
		flat[7:0] = 8'h00;
		return flat;
	endfunction

	task automatic push_cmd(input in_t c);
		if (!(items_sent >= QUIET_FROM && items_sent < QUIET_TO) &&
			$urandom_range(0, 99) < 14) begin
			start <= 1'b0;
			cmd <= random_cmd();
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		// busy only moves on a rising edge, so its value here decides the next edge.
		while (busy) @(negedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic apb_write(input logic [4:0] addr, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		while (!pready) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic set_exclusion(input name_t v);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		for (int i = 0; i < NAME_WORDS; i++) begin
			apb_write(EXCLUDE_ADDR[i], v[i]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		excl_now = v;
	endtask

	initial begin
		logic [255:0] flat;
		int len;
		int r;
		int n;
		int m;
		int phase_start;
		bit in_order;
		name_t exclusions [PHASES];

		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		items_sent = 0;
		excl_now = '0;

		// Pool of names: a one-byte name, two full 32-byte names that differ only in
		// their last byte, and a name that is a prefix of another.
		for (int k = 0; k < POOL_SIZE; k++) begin
			len = (k == 0) ? 1 : (k < 3) ? 32 : $urandom_range(2, 31);
			flat = '0;
			for (int j = 0; j < len; j++) begin
				flat[8*j +: 8] = 8'($urandom_range(1, 255));
			end
			pool[k] = flat;
		end
		pool[3] = pool[2];
		pool[3][3][63:56] = (pool[2][3][63:56] == 8'h7F) ? 8'h80 : 8'h7F;
		flat = pool[5];
		for (int j = 31; j > 0; j--) begin
			if (flat[8*j +: 8] != 8'h00) begin
				flat[8*j +: 8] = 8'h00;
				break;
			end
		end
		pool[4] = flat;

		exclusions[0] = '0;
		exclusions[1] = pool[5];
		exclusions[2] = '1;
		exclusions[3] = with_junk_tail(pool[6]);
		exclusions[4] = pool[7];
		exclusions[4][0][7:0] = 8'h00;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_cmd(read_cmd(4'd0));
		push_cmd(read_cmd(4'd15));
		flat = {rand64(), rand64(), rand64(), rand64()};
		flat[7:0] = 8'h00;
		push_cmd(offer_cmd(flat, 8'sd5, 1'b0));
		push_cmd(offer_cmd(pool[0], 8'sh80, 1'b0));
		push_cmd(offer_cmd(pool[1], 8'sh7F, 1'b0));
		push_cmd(offer_cmd(with_junk_tail(pool[0]), 8'sh80, 1'b0));
		push_cmd(offer_cmd(with_junk_tail(pool[0]), -8'sd10, 1'b0));
		push_cmd(offer_cmd(pool[2], -8'sd10, 1'b0));
		push_cmd(offer_cmd(pool[3], -8'sd10, 1'b0));
		push_cmd(offer_cmd(pool[4], 8'sh7F, 1'b0));
		push_cmd(offer_cmd(pool[5], 8'sh80, 1'b1));
		push_cmd(offer_cmd(pool[1], 8'sd126, 1'b0));
		begin
			in_t c;
			c = random_cmd();
			c.action = ACT_SPARE;
			c.batch_end = 1'b1;
			push_cmd(c);
		end
		for (int j = 0; j < 7; j++) begin
			push_cmd(read_cmd(4'(j)));
		end
		push_cmd(offer_cmd(pool[0], 8'sd0, 1'b0) ^ '0);
		begin
			in_t c;
			c = random_cmd();
			c.action = ACT_CLEAR;
			push_cmd(c);
		end
		push_cmd(read_cmd(4'd0));
		push_cmd(offer_cmd(pool[5], 8'sd0, 1'b1));

		for (int p = 0; p < PHASES; p++) begin
			set_exclusion(exclusions[p]);
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 6) begin
					in_t c;
					c = random_cmd();
					c.action = ACT_CLEAR;
					push_cmd(c);
				end else if (r < 16) begin
					push_cmd(random_cmd());
				end else begin
					// One scan: a batch of sightings, then reads from the table, in order or at random.
					n = $urandom_range(2, 20);
					for (int j = 0; j < n; j++) begin
						push_cmd(offer_cmd(pick_name(), pick_strength(),
							(j == n - 1) || ($urandom_range(0, 9) == 0)));
					end
					m = $urandom_range(1, 16);
					in_order = 1'($urandom_range(0, 1));
					for (int j = 0; j < m; j++) begin
						push_cmd(read_cmd(in_order ? 4'(j) : 4'($urandom_range(0, 15))));
					end
				end
			end
		end

		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb_top_k_signal_table_with_dedup_unit passed");
		end else begin
			$display("tb_top_k_signal_table_with_dedup_unit failed");
		end
		$finish;
	end

endmodule

FILE: top_k_signal_table_with_dedup_unit.f
hdl/tks_pkg.sv
hdl/tks_entry_ram.sv
hdl/top_k_signal_table_with_dedup_unit.sv
tb/signal_table_checker.sv
tb/tb_top_k_signal_table_with_dedup_unit.sv
